FILE: design/i2cms_pkg.sv
// Package for the I2C master bit sequencer: command codes, phase counts and reset values.
// No dependencies; used by design/i2c_master_bit_sequencer.sv.
`default_nettype none

package i2cms_pkg;

    // Command codes carried on the op field
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_START   = 3'd1,
        OP_RESTART = 3'd2,
        OP_STOP    = 3'd3,
        OP_WRITE   = 3'd4,
        OP_READ    = 3'd5,
        OP_ACK     = 3'd6,
        OP_NACK    = 3'd7
    } t_op;

    localparam int unsigned DIVIDER_WIDTH_DEF = 16;
    localparam int unsigned QT_WIDTH          = 16;
    localparam logic [QT_WIDTH-1:0] QUARTER_TICKS_RST = 16'd250;

    // Quarter-bit phases per command
    localparam logic [5:0] PHASES_SHORT = 6'd4;
    localparam logic [5:0] PHASES_WRITE = 6'd36;
    localparam logic [5:0] PHASES_READ  = 6'd32;

    // Number of data bits in a byte; bit slots at or above this are the ack slot
    localparam logic [3:0] BYTE_BITS = 4'd8;

    function automatic logic [5:0] phase_total(input t_op cmd);
        logic [5:0] tot;
        begin
            case (cmd)
                OP_WRITE: tot = PHASES_WRITE;
                OP_READ:  tot = PHASES_READ;
                default:  tot = PHASES_SHORT;
            endcase
            return tot;
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: one word in per clock tick, one result word out per word in.
// The result word of an accepted word is in the output register in the next cycle.
// Throughput: one word per cycle; input ready while the output register is empty or being taken.
// Phase timing is a counter against the quarter_ticks divider register, one step per word.
// Reset (synchronous, active low): idle, both lines released, ack bit 1, divider 250.
// Depends on design/i2cms_pkg.sv.
`default_nettype none

module i2c_master_bit_sequencer #(
    parameter int unsigned DIVIDER_WIDTH = i2cms_pkg::DIVIDER_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // divider register write
    input  wire logic                          i_cfg_we,
    input  wire logic [i2cms_pkg::QT_WIDTH-1:0] i_cfg_data,
    // input words
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [2:0]                    i_op,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_sda_in,
    // result words
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_scl_out,
    output logic                               o_sda_out,
    output logic                               o_busy_res,
    output logic                               o_done_res,
    output logic                               o_ack_bit,
    output logic [7:0]                         o_rx_byte,
    output logic                               o_cmd_rejected
);
    import i2cms_pkg::*;

    // width wide enough for the divider, the saturation limit and the incremented count
    localparam int unsigned LW = ((DIVIDER_WIDTH > QT_WIDTH) ? DIVIDER_WIDTH : QT_WIDTH) + 1;

    // sequencer state
    logic [QT_WIDTH-1:0]      r_qt;
    t_op                      r_cmd,   n_cmd;
    logic [5:0]               r_phase, n_phase;
    logic [DIVIDER_WIDTH-1:0] r_tick,  n_tick;
    logic [7:0]               r_shift, n_shift;
    logic                     r_scl,   n_scl;
    logic                     r_sda,   n_sda;
    logic                     r_ack,   n_ack;
    logic [7:0]               r_rx,    n_rx;

    // output register
    logic r_out_valid;
    logic r_done, n_done;
    logic r_rej,  n_rej;
    logic r_busy_o, r_scl_o, r_sda_o, r_ack_o;
    logic [7:0] r_rx_o;

    logic accept;
    logic [LW-1:0] qt_ext, lim, len, inc_ext;
    logic [DIVIDER_WIDTH:0] tick_inc;
    t_op ent_cmd;
    logic [5:0] ent_phase;
    logic ent_en;
    logic [5:0] phase_nx;
    logic [1:0] q;
    logic [3:0] bslot;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // effective phase length: zero acts as one, saturate at 2^DIVIDER_WIDTH
    always_comb begin
        qt_ext = LW'(r_qt);
        lim    = LW'(1) << DIVIDER_WIDTH;
        if (qt_ext == '0) begin
            len = LW'(1);
        end else if (qt_ext > lim) begin
            len = lim;
        end else begin
            len = qt_ext;
        end
    end

    // next state for one tick
    always_comb begin
        n_cmd     = r_cmd;
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_shift   = r_shift;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_ack     = r_ack;
        n_rx      = r_rx;
        n_done    = 1'b0;
        n_rej     = 1'b0;
        ent_en    = 1'b0;
        ent_cmd   = r_cmd;
        ent_phase = '0;
        tick_inc  = {1'b0, r_tick} + 1'b1;
        inc_ext   = LW'(tick_inc);
        phase_nx  = r_phase + 6'd1;

        if (r_cmd != OP_NONE) begin
            n_rej = (t_op'(i_op) != OP_NONE);
            if (inc_ext >= len) begin
                n_tick = '0;
                if (phase_nx >= phase_total(r_cmd)) begin
                    // command finishes on this tick
                    if (r_cmd == OP_WRITE) n_ack = i_sda_in;
                    if (r_cmd == OP_READ)  n_rx  = r_shift;
                    n_cmd   = OP_NONE;
                    n_phase = '0;
                    n_done  = 1'b1;
                end else begin
                    n_phase   = phase_nx;
                    ent_en    = 1'b1;
                    ent_phase = phase_nx;
                end
            end else begin
                n_tick = tick_inc[DIVIDER_WIDTH-1:0];
            end
        end else if (t_op'(i_op) != OP_NONE) begin
            // idle: take the new command, phase 0 actions on this tick
            n_cmd   = t_op'(i_op);
            n_phase = '0;
            n_tick  = '0;
            ent_cmd = t_op'(i_op);
            ent_en  = 1'b1;
            if (t_op'(i_op) == OP_WRITE) begin
                n_shift = i_data_byte;
            end else if (t_op'(i_op) == OP_READ) begin
                n_shift = '0;
            end
        end

        // line actions on entry to a phase
        q     = ent_phase[1:0];
        bslot = ent_phase[5:2];
        if (ent_en) begin
            case (ent_cmd)
                OP_START: begin
                    if (q == 2'd0) begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                    end else if (q == 2'd2) begin
                        n_sda = 1'b0;
                    end
                end
                OP_RESTART, OP_STOP: begin
                    if (q == 2'd0)      n_scl = 1'b0;
                    else if (q == 2'd1) n_sda = (ent_cmd == OP_RESTART);
                    else if (q == 2'd2) n_scl = 1'b1;
                    else                n_sda = (ent_cmd == OP_STOP);
                end
                OP_ACK, OP_NACK: begin
                    if (q == 2'd0)      n_scl = 1'b0;
                    else if (q == 2'd1) n_sda = (ent_cmd == OP_NACK);
                    else if (q == 2'd2) n_scl = 1'b1;
                end
                OP_WRITE: begin
                    if (bslot < BYTE_BITS) begin
                        if (q == 2'd0)      n_scl = 1'b0;
                        else if (q == 2'd1) n_sda = n_shift[3'd7 - bslot[2:0]];
                        else if (q == 2'd2) n_scl = 1'b1;
                    end else begin
                        // ack slot: release SDA for the slave
                        if (q == 2'd0) begin
                            n_scl = 1'b0;
                            n_sda = 1'b1;
                        end else if (q == 2'd2) begin
                            n_scl = 1'b1;
                        end
                    end
                end
                OP_READ: begin
                    if (bslot < BYTE_BITS) begin
                        if (q == 2'd0) begin
                            n_scl = 1'b0;
                            n_sda = 1'b1;
                        end else if (q == 2'd2) begin
                            n_scl = 1'b1;
                        end else if (q == 2'd3) begin
                            n_shift[3'd7 - bslot[2:0]] = n_shift[3'd7 - bslot[2:0]] | i_sda_in;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // divider register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qt <= QUARTER_TICKS_RST;
        end else if (i_cfg_we) begin
            r_qt <= i_cfg_data;
        end
    end

    // sequencer state, advanced once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= OP_NONE;
            r_phase <= '0;
            r_tick  <= '0;
            r_shift <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_ack   <= 1'b1;
            r_rx    <= '0;
        end else if (accept) begin
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
            r_rx    <= n_rx;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_scl_o  <= n_scl;
            r_sda_o  <= n_sda;
            r_busy_o <= (n_cmd != OP_NONE);
            r_done   <= n_done;
            r_ack_o  <= n_ack;
            r_rx_o   <= n_rx;
            r_rej    <= n_rej;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_out      = r_scl_o;
    assign o_sda_out      = r_sda_o;
    assign o_busy_res     = r_busy_o;
    assign o_done_res     = r_done;
    assign o_ack_bit      = r_ack_o;
    assign o_rx_byte      = r_rx_o;
    assign o_cmd_rejected = r_rej;

    // checks
    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd != OP_NONE) |-> (r_phase < phase_total(r_cmd)))
        else $error("phase index beyond command length");

    a_idle_phase_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == OP_NONE) |-> (r_phase == '0))
        else $error("idle with nonzero phase index");

    a_tick_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd != OP_NONE) |-> (LW'(r_tick) < len))
        else $error("tick count reached phase length");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_busy_res)
        else $error("done word reports busy");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_cmd == OP_NONE && t_op'(i_op) != OP_NONE) |=> (r_cmd != OP_NONE))
        else $error("command from idle not taken");

endmodule

`default_nettype wire
